>>> rtl/jhd_pkg.sv
// Shared types, codes and helper functions for the JPEG Huffman block decoder.
// Used by jhd_out and jpeg_huffman_block_decoder; depends on nothing else.
package jhd_pkg;

    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_COUNT = 2'd1;
    localparam logic [1:0] REQ_SYM   = 2'd2;
    localparam logic [1:0] REQ_START = 2'd3;

    localparam logic [1:0] RES_COEF = 2'd0;
    localparam logic [1:0] RES_EOB  = 2'd1;
    localparam logic [1:0] RES_ERR  = 2'd2;

    localparam logic [1:0] PH_DC_CODE = 2'd0;
    localparam logic [1:0] PH_DC_MAG  = 2'd1;
    localparam logic [1:0] PH_AC_CODE = 2'd2;
    localparam logic [1:0] PH_AC_MAG  = 2'd3;

    localparam logic [2:0] CFG_COUNT = 3'd6;
    localparam logic [5:0] CFG_RESET = 6'b110110;
    localparam logic [2:0] CFG_AC_BASE = 3'd3;

    localparam logic [7:0] RUN_MASK  = 8'hF0;
    localparam logic [7:0] SIZE_MASK = 8'h0F;
    localparam logic [7:0] DC_SIZE_MAX = 8'd15;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_value;
        logic [1:0] table_id;
        logic [7:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [1:0]         component;
        logic [5:0]         position;
        logic signed [15:0] coef_value;
        logic               last;
    } t_res;

    function automatic logic [15:0] extend_mag(input logic [15:0] bits, input logic [3:0] size);
        logic [16:0] m;
        logic [15:0] r;
        m = (17'd1 << size) - 17'd1;
        if (size == 4'd0) begin
            r = 16'd0;
        end else if (bits[size - 4'd1] == 1'b0) begin
            r = bits - m[15:0];
        end else begin
            r = bits;
        end
        return r;
    endfunction

endpackage

>>> rtl/jhd_out.sv
// Output register stage for decoded result beats.
// Depends on jhd_pkg for the result beat type.
module jhd_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jhd_pkg::t_res i_beat,
    input  logic          i_stall,
    output logic          o_valid,
    output jhd_pkg::t_res o_beat,
    output logic          o_free
);
    import jhd_pkg::*;

    logic r_valid;
    t_res r_beat;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_beat <= i_beat;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_free))
        else $error("beat pushed over a held beat");

endmodule

>>> rtl/jpeg_huffman_block_decoder.sv
// Baseline JPEG Huffman entropy decoder: tables, bit-serial decode, result staging.
// Depends on jhd_pkg and jhd_out.
// Count and symbol load beats are written while idle. A start beat builds the derived
// tables with one read and one write of the derived-table memory per code length.
// A scan byte is decoded bit by bit: a magnitude bit is taken in S_BIT; a code bit
// passes S_BIT (count, first-code read), S_LOOK and on a match S_SYM (symbol read).
// Reset clears control state and the count valid bits; the symbol memory is not cleared.
module jpeg_huffman_block_decoder #(
    parameter int NUM_TABLES        = 4,
    parameter int MAX_CODE_LENGTH   = 16,
    parameter int SYMBOLS_PER_TABLE = 256,
    parameter int COEFFS_PER_BLOCK  = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  jhd_pkg::t_req i_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output jhd_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [0:0]    i_cfg_data
);
    import jhd_pkg::*;

    localparam int NCNT = NUM_TABLES * MAX_CODE_LENGTH;
    localparam int CAW  = $clog2(NCNT);
    localparam int NSYM = NUM_TABLES * SYMBOLS_PER_TABLE;
    localparam int SAW  = $clog2(NSYM);
    localparam int TW   = $clog2(NUM_TABLES);
    localparam int LW   = $clog2(MAX_CODE_LENGTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_BIT   = 8'b00000010,
        S_LOOK  = 8'b00000100,
        S_SYM   = 8'b00001000,
        S_EOB   = 8'b00010000,
        S_FLUSH = 8'b00100000,
        S_BRD   = 8'b01000000,
        S_BWR   = 8'b10000000
    } t_state;

    logic [7:0]  cnt_mem [NCNT];
    logic [24:0] drv_mem [NCNT];
    logic [7:0]  sym_mem [NSYM];

    t_state      r_state, n_state;
    logic [5:0]  r_cfg;
    logic [NCNT-1:0] r_cnt_vld;
    logic        r_built, n_built;
    logic [3:0]  r_longest [NUM_TABLES];
    logic [15:0] r_pred [3];
    logic [15:0] n_pred [3];
    logic [15:0] r_acc, n_acc;
    logic [4:0]  r_len, n_len;
    logic [15:0] r_mag, n_mag;
    logic [3:0]  r_mrem, n_mrem;
    logic [1:0]  r_phase, n_phase;
    logic [6:0]  r_pos, n_pos;
    logic [1:0]  r_comp, n_comp;
    logic [7:0]  r_byte, n_byte;
    logic [2:0]  r_bit, n_bit;
    logic [TW-1:0] r_bt, n_bt;
    logic [LW-1:0] r_bi, n_bi;
    logic [15:0] r_bfirst, n_bfirst;
    logic [11:0] r_boff, n_boff;
    logic        r_pend_v, n_pend_v;
    t_res        r_pend, n_pend;

    logic [7:0]  r_cnt_q;
    logic        r_cnt_vq;
    logic [24:0] r_drv_q;
    logic [7:0]  r_sym_q;

    logic        c_accept, c_out_free, c_push;
    t_res        c_push_beat;
    logic        c_rd_en, c_sym_rd, c_cnt_we, c_sym_we, c_drv_we, c_lng_we;
    logic [CAW-1:0] c_rd_addr, c_cnt_waddr, c_baddr;
    logic [SAW-1:0] c_sym_addr, c_sym_waddr;
    logic [24:0] c_drv_wdata;
    logic [3:0]  c_lng_wdata;
    logic [3:0]  c_t4;
    logic [TW-1:0] c_tm;
    logic        c_bitv;
    logic [7:0]  c_cnt;
    logic [15:0] c_first, c_diff, c_v, c_pv;
    logic [8:0]  c_off;
    logic [9:0]  c_si;
    logic [15:0] c_mag;
    logic [3:0]  c_mrem;
    logic [3:0]  c_run, c_size;
    logic [6:0]  c_np, c_np1;
    logic        e_v, nb, adv;
    logic [1:0]  e_kind;
    logic [6:0]  e_pos;
    logic [15:0] e_val;

    assign c_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign c_baddr    = CAW'(int'(r_bt) * MAX_CODE_LENGTH + int'(r_bi));

    always_comb begin
        c_t4 = (r_phase == PH_DC_CODE || r_phase == PH_DC_MAG) ?
               {3'd0, r_cfg[3'(r_comp)]} : {3'd0, r_cfg[3'(r_comp) + CFG_AC_BASE]} + 4'd2;
        if (int'(c_t4) >= NUM_TABLES) begin
            c_tm = TW'(int'(c_t4) - NUM_TABLES);
        end else begin
            c_tm = TW'(c_t4);
        end
    end

    always_comb begin
        c_cnt   = r_cnt_vq ? r_cnt_q : 8'd0;
        c_first = r_built ? r_drv_q[24:9] : 16'd0;
        c_off   = r_built ? r_drv_q[8:0] : 9'd0;
        c_diff  = r_acc - c_first;
        c_si    = {1'b0, c_off} + {2'd0, c_diff[7:0]};
        c_bitv  = r_byte[3'd7 - r_bit];
        c_mag   = {r_mag[14:0], c_bitv};
        c_mrem  = (r_mrem != 4'd0) ? r_mrem - 4'd1 : 4'd0;
        c_v     = extend_mag(c_mag, r_len[3:0]);
        c_run   = 4'((r_sym_q & RUN_MASK) >> 4);
        c_size  = 4'(r_sym_q & SIZE_MASK);
        c_np    = r_pos + {3'd0, c_run};
        c_np1   = c_np + 7'd1;
    end

    always_comb begin
        n_state = r_state; n_built = r_built; n_pred = r_pred;
        n_acc = r_acc; n_len = r_len; n_mag = r_mag; n_mrem = r_mrem;
        n_phase = r_phase; n_pos = r_pos; n_comp = r_comp;
        n_byte = r_byte; n_bit = r_bit; n_bt = r_bt; n_bi = r_bi;
        n_bfirst = r_bfirst; n_boff = r_boff; n_pend_v = r_pend_v; n_pend = r_pend;
        c_rd_en = 1'b0; c_rd_addr = c_baddr; c_sym_rd = 1'b0; c_sym_addr = '0;
        c_cnt_we = 1'b0; c_cnt_waddr = '0; c_sym_we = 1'b0; c_sym_waddr = '0;
        c_drv_we = 1'b0; c_drv_wdata = '0; c_lng_we = 1'b0; c_lng_wdata = '0;
        c_push = 1'b0; c_push_beat = r_pend; c_pv = '0;
        e_v = 1'b0; e_kind = RES_COEF; e_pos = '0; e_val = '0; nb = 1'b0; adv = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    case (i_req.req_type)
                        REQ_DATA: begin
                            n_byte = i_req.byte_value;
                            n_bit = 3'd0;
                            n_state = S_BIT;
                        end
                        REQ_COUNT: begin
                            if (int'(i_req.table_id) < NUM_TABLES &&
                                int'(i_req.entry_index) < MAX_CODE_LENGTH) begin
                                c_cnt_we = 1'b1;
                                c_cnt_waddr = CAW'(int'(i_req.table_id) * MAX_CODE_LENGTH +
                                                   int'(i_req.entry_index));
                            end
                        end
                        REQ_SYM: begin
                            if (int'(i_req.table_id) < NUM_TABLES &&
                                int'(i_req.entry_index) < SYMBOLS_PER_TABLE) begin
                                c_sym_we = 1'b1;
                                c_sym_waddr = SAW'(int'(i_req.table_id) * SYMBOLS_PER_TABLE +
                                                   int'(i_req.entry_index));
                            end
                        end
                        default: begin
                            n_pred[0] = '0; n_pred[1] = '0; n_pred[2] = '0;
                            n_comp = 2'd0; n_phase = PH_DC_CODE; n_pos = '0;
                            n_acc = '0; n_len = '0; n_mag = '0; n_mrem = '0;
                            n_bt = '0; n_bi = '0;
                            n_state = S_BRD;
                        end
                    endcase
                end
            end
            S_BRD: begin
                c_rd_en = 1'b1;
                n_state = S_BWR;
            end
            S_BWR: begin
                c_drv_we = 1'b1;
                if (r_bi == '0) begin
                    c_drv_wdata = 25'd0;
                    n_bfirst = 16'({16'd0, 8'd0, r_cnt_q & {8{r_cnt_vq}}} << 1);
                    n_boff = {4'd0, c_cnt};
                    c_lng_we = 1'b1;
                    c_lng_wdata = 4'd0;
                end else begin
                    c_drv_wdata = {r_bfirst, (r_boff > 12'd511) ? 9'd511 : r_boff[8:0]};
                    n_bfirst = 16'((r_bfirst + {8'd0, c_cnt}) << 1);
                    n_boff = r_boff + {4'd0, c_cnt};
                end
                if (c_cnt != 8'd0) begin
                    c_lng_we = 1'b1;
                    c_lng_wdata = 4'(r_bi);
                end
                n_state = S_BRD;
                if (r_bi == LW'(MAX_CODE_LENGTH - 1)) begin
                    n_bi = '0;
                    if (r_bt == TW'(NUM_TABLES - 1)) begin
                        n_built = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_bt = r_bt + 1'b1;
                    end
                end else begin
                    n_bi = r_bi + 1'b1;
                end
            end
            S_BIT: begin
                if (c_out_free) begin
                    if (r_phase == PH_DC_CODE || r_phase == PH_AC_CODE) begin
                        n_acc = {r_acc[14:0], c_bitv};
                        n_len = r_len + 5'd1;
                        if (int'(n_len) > MAX_CODE_LENGTH) begin
                            e_v = 1'b1; e_kind = RES_ERR; e_pos = r_pos;
                            nb = 1'b1; adv = 1'b1;
                        end else begin
                            c_rd_en = 1'b1;
                            c_rd_addr = CAW'(int'(c_tm) * MAX_CODE_LENGTH + int'(n_len) - 1);
                            n_state = S_LOOK;
                        end
                    end else begin
                        n_mag = c_mag;
                        n_mrem = c_mrem;
                        adv = 1'b1;
                        if (c_mrem == 4'd0) begin
                            n_len = '0;
                            n_mag = '0;
                            if (r_phase == PH_DC_MAG) begin
                                c_pv = r_pred[r_comp] + c_v;
                                n_pred[r_comp] = c_pv;
                                e_v = 1'b1; e_kind = RES_COEF; e_pos = '0; e_val = c_pv;
                                n_pos = 7'd1; n_phase = PH_AC_CODE;
                            end else begin
                                e_v = 1'b1; e_kind = RES_COEF; e_pos = r_pos; e_val = c_v;
                                n_pos = r_pos + 7'd1;
                                if (int'(r_pos) + 1 >= COEFFS_PER_BLOCK) begin
                                    adv = 1'b0;
                                    n_state = S_EOB;
                                end else begin
                                    n_phase = PH_AC_CODE;
                                end
                            end
                        end
                    end
                end
            end
            S_LOOK: begin
                if (c_out_free) begin
                    if (c_cnt == 8'd0 || r_acc < c_first || c_diff >= {8'd0, c_cnt}) begin
                        adv = 1'b1;
                        if ((r_len - 5'd1) >= {1'b0, r_longest[c_tm]}) begin
                            e_v = 1'b1; e_kind = RES_ERR; e_pos = r_pos; nb = 1'b1;
                        end
                    end else if (int'(c_si) >= SYMBOLS_PER_TABLE) begin
                        adv = 1'b1;
                        e_v = 1'b1; e_kind = RES_ERR; e_pos = r_pos; nb = 1'b1;
                    end else begin
                        c_sym_rd = 1'b1;
                        c_sym_addr = SAW'(int'(c_tm) * SYMBOLS_PER_TABLE + int'(c_si));
                        n_state = S_SYM;
                    end
                end
            end
            S_SYM: begin
                if (c_out_free) begin
                    adv = 1'b1;
                    n_acc = '0;
                    n_len = '0;
                    if (r_phase == PH_DC_CODE) begin
                        if (r_sym_q > DC_SIZE_MAX) begin
                            e_v = 1'b1; e_kind = RES_ERR; e_pos = r_pos; nb = 1'b1;
                        end else if (r_sym_q == 8'd0) begin
                            c_pv = r_pred[r_comp];
                            e_v = 1'b1; e_kind = RES_COEF; e_pos = '0; e_val = c_pv;
                            n_pos = 7'd1; n_phase = PH_AC_CODE;
                        end else begin
                            n_len = r_sym_q[4:0];
                            n_mrem = r_sym_q[3:0];
                            n_mag = '0;
                            n_phase = PH_DC_MAG;
                        end
                    end else if (r_sym_q == 8'd0) begin
                        e_v = 1'b1; e_kind = RES_EOB; nb = 1'b1;
                    end else if (int'(c_np) > COEFFS_PER_BLOCK - 1) begin
                        e_v = 1'b1; e_kind = RES_ERR; e_pos = r_pos; nb = 1'b1;
                    end else if (c_size == 4'd0) begin
                        if (int'(c_np1) >= COEFFS_PER_BLOCK) begin
                            e_v = 1'b1; e_kind = RES_EOB; nb = 1'b1;
                        end else begin
                            n_pos = c_np1;
                            n_phase = PH_AC_CODE;
                        end
                    end else begin
                        n_pos = c_np;
                        n_len = {1'b0, c_size};
                        n_mrem = c_size;
                        n_mag = '0;
                        n_phase = PH_AC_MAG;
                    end
                end
            end
            S_EOB: begin
                if (c_out_free) begin
                    e_v = 1'b1; e_kind = RES_EOB; nb = 1'b1; adv = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (c_out_free) begin
                    c_push = 1'b1;
                    c_push_beat = r_pend;
                    c_push_beat.last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (e_v) begin
            c_push = r_pend_v;
            n_pend_v = 1'b1;
            n_pend.result_kind = e_kind;
            n_pend.component = r_comp;
            n_pend.position = e_pos[5:0];
            n_pend.coef_value = e_val;
            n_pend.last = 1'b0;
        end
        if (nb) begin
            n_comp = (r_comp >= 2'd2) ? 2'd0 : r_comp + 2'd1;
            n_phase = PH_DC_CODE; n_pos = '0;
            n_acc = '0; n_len = '0; n_mag = '0; n_mrem = '0;
        end
        if (adv) begin
            if (r_bit == 3'd7) begin
                n_state = S_FLUSH;
            end else begin
                n_bit = r_bit + 3'd1;
                n_state = S_BIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg <= CFG_RESET;
            r_cnt_vld <= '0;
            r_built <= 1'b0;
            r_pred <= '{default: '0};
            r_acc <= '0; r_len <= '0; r_mag <= '0; r_mrem <= '0;
            r_phase <= PH_DC_CODE; r_pos <= '0; r_comp <= '0;
            r_bit <= '0; r_bt <= '0; r_bi <= '0;
            r_pend_v <= 1'b0;
            for (int k = 0; k < NUM_TABLES; k++) begin
                r_longest[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx < CFG_COUNT) begin
                r_cfg[i_cfg_idx] <= i_cfg_data[0];
            end
            if (c_cnt_we) begin
                r_cnt_vld[c_cnt_waddr] <= 1'b1;
            end
            if (c_lng_we) begin
                r_longest[r_bt] <= c_lng_wdata;
            end
            r_built <= n_built; r_pred <= n_pred;
            r_acc <= n_acc; r_len <= n_len; r_mag <= n_mag; r_mrem <= n_mrem;
            r_phase <= n_phase; r_pos <= n_pos; r_comp <= n_comp;
            r_bit <= n_bit; r_bt <= n_bt; r_bi <= n_bi;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_bfirst <= n_bfirst;
        r_boff <= n_boff;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (c_cnt_we) begin
            cnt_mem[c_cnt_waddr] <= i_req.byte_value;
        end
        if (c_rd_en) begin
            r_cnt_q <= cnt_mem[c_rd_addr];
            r_cnt_vq <= r_cnt_vld[c_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_drv_we) begin
            drv_mem[c_baddr] <= c_drv_wdata;
        end
        if (c_rd_en) begin
            r_drv_q <= drv_mem[c_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_sym_we) begin
            sym_mem[c_sym_waddr] <= i_req.byte_value;
        end
        if (c_sym_rd) begin
            r_sym_q <= sym_mem[c_sym_addr];
        end
    end

    jhd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_beat  (c_push_beat),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_beat  (o_res),
        .o_free  (c_out_free)
    );

    a_start_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && i_req.req_type == REQ_START) |=> (r_state == S_BRD))
        else $error("start beat did not begin the table build");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EOB) |-> (int'(r_pos) < COEFFS_PER_BLOCK))
        else $error("coefficient position past end of block");

    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comp != 2'd3)
        else $error("component index out of range");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("result still pending while idle");

endmodule
